@@ rtl/core/dbd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants for the detection box decoder.
// ----------------------------------------------------------------------------
package dbd_pkg;

    // Field widths
    localparam int VALUE_W = 20;   // raw box value or score, signed
    localparam int SCORE_W = 16;   // Q0.16 score / threshold
    localparam int CLASS_W = 7;    // class id
    localparam int COORD_W = 18;   // output coordinate, 5 fraction bits
    localparam int NET_W   = 13;   // network size register
    localparam int CNT8_W  = 8;    // class count registers

    // Threshold table
    localparam int TABLE_DEPTH = 128;
    localparam int TABLE_AW    = 7;

    localparam logic [SCORE_W-1:0] DEFAULT_THRESHOLD = 16'h4000;  // 0.25
    localparam logic [NET_W-1:0]   MAX_NET           = 13'd4096;
    localparam int                 MIN_SIZE          = 32;        // one pixel

    // Stream data widths (byte padded)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 96;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_CLASSES    = 2'd0,
        CFG_NUM_THRESHOLDS = 2'd1,
        CFG_NET_WIDTH      = 2'd2,
        CFG_NET_HEIGHT     = 2'd3
    } cfg_index_t;

    // Input kind carried in tuser
    typedef enum logic {
        MODE_ANCHOR = 1'b0,
        MODE_TABLE  = 1'b1
    } mode_t;

endpackage

@@ rtl/core/dbd_ram.sv @@
// ----------------------------------------------------------------------------
// dbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/detection_box_decoder.sv @@
// ----------------------------------------------------------------------------
// detection_box_decoder
// Streams one anchor's values (cx, cy, w, h, class scores), tracks the best
// class, checks it against a per-class threshold table and emits clamped
// corner boxes with 5 fraction bits.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                   Payload
//  -------   ---  --------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid/tready        tdata: value, table_index
//                                             tuser: mode, tlast: final_anchor
//  m_axis    out  m_axis_tvalid/tready        tdata: class_id .. height
//                                             tuser: detected, tlast: frame_end
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
//  One input request per cycle while s_axis_tready is high. A result passes
//  three registers after the anchor's last score is accepted: table read,
//  corner clamp, size check / output reg.
//  Threshold table is a 128-entry RAM read once per anchor; no clearing pass.
//  Reset loads the default configuration and clears the position counter, anchor state and pipeline valids.
//  A stalled m_axis backs up through the pipeline into s_axis_tready.
//
module detection_box_decoder #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [19:0] value, [26:20] table_index, [31:27] zero
    input  logic [dbd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [6:0] class_id, [22:7] score, [40:23] left, [58:41] top,
    // [76:59] width, [94:77] height, [95] zero
    output logic [dbd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] detected
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [dbd_pkg::NET_W-1:0]          cfg_data
);

    import dbd_pkg::*;

    // Effective class limit: the count register is 8 bits wide
    localparam int CLS_MAX = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int CNT_W   = $clog2(CLS_MAX + 4);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT8_W-1:0] num_classes_reg;
    logic [CNT8_W-1:0] num_thresholds_reg;
    logic [NET_W-1:0]  net_width_reg;
    logic [NET_W-1:0]  net_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg    <= 8'd80;
            num_thresholds_reg <= 8'd0;
            net_width_reg      <= 13'd640;
            net_height_reg     <= 13'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NUM_CLASSES:    num_classes_reg    <= cfg_data[CNT8_W-1:0];
                CFG_NUM_THRESHOLDS: num_thresholds_reg <= cfg_data[CNT8_W-1:0];
                CFG_NET_WIDTH:      net_width_reg      <= cfg_data;
                CFG_NET_HEIGHT:     net_height_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0]  in_value;
    logic [TABLE_AW-1:0]        in_tidx;
    logic                       in_accept;
    logic                       is_table;
    logic                       anchor_acc;
    logic [SCORE_W-1:0]         val_sat;

    assign in_value   = $signed(s_axis_tdata[VALUE_W-1:0]);
    assign in_tidx    = s_axis_tdata[VALUE_W +: TABLE_AW];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign is_table   = (mode_t'(s_axis_tuser) == MODE_TABLE);
    assign anchor_acc = in_accept && !is_table;

    // saturate to Q0.16
    always_comb
    begin
        if (in_value[VALUE_W-1])
        begin
            val_sat = '0;
        end
        else if (|in_value[VALUE_W-2:SCORE_W])
        begin
            val_sat = '1;
        end
        else
        begin
            val_sat = in_value[SCORE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Anchor state: position, box, running argmax
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] box_reg [4];
    logic [SCORE_W-1:0]        best_score_reg;
    logic [CLASS_W-1:0]        best_class_reg;

    logic [CNT_W:0]            cls_eff;
    logic                      pos_is_box;
    logic                      last_pos;
    logic                      better;
    logic [CLASS_W-1:0]        cand_class;
    logic [SCORE_W-1:0]        best_score_next;
    logic [CLASS_W-1:0]        best_class_next;
    logic                      done;
    logic                      use_table;

    always_comb
    begin
        if (num_classes_reg == '0)
        begin
            cls_eff = (CNT_W+1)'(1);
        end
        else if (int'(num_classes_reg) > CLS_MAX)
        begin
            cls_eff = (CNT_W+1)'(CLS_MAX);
        end
        else
        begin
            cls_eff = (CNT_W+1)'(num_classes_reg);
        end
    end

    assign pos_is_box = (pos_reg < CNT_W'(4));
    assign last_pos   = ({1'b0, pos_reg} >= (cls_eff + (CNT_W+1)'(3)));
    assign better     = (pos_reg == CNT_W'(4)) || (val_sat > best_score_reg);
    assign cand_class = CLASS_W'(pos_reg - CNT_W'(4));

    assign best_score_next = better ? val_sat    : best_score_reg;
    assign best_class_next = better ? cand_class : best_class_reg;
    assign done            = anchor_acc && !pos_is_box && last_pos;
    assign use_table       = ({1'b0, best_class_next} < num_thresholds_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (anchor_acc)
        begin
            if (pos_is_box)
            begin
                box_reg[pos_reg[1:0]] <= in_value;
                pos_reg               <= pos_reg + CNT_W'(1);
            end
            else
            begin
                best_score_reg <= best_score_next;
                best_class_reg <= best_class_next;
                pos_reg        <= last_pos ? '0 : pos_reg + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Threshold table
    // ------------------------------------------------------------------
    logic [SCORE_W-1:0] thr_rdata;

    dbd_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_thr_ram (
        .clk   (clk),
        .we    (in_accept && is_table),
        .waddr (in_tidx),
        .wdata (val_sat),
        .re    (done),
        .raddr (best_class_next),
        .rdata (thr_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_free, s2_produce, s2_move, s2_free, s1_move, s1_free;

    logic s2_keep;
    logic s2_fin_reg;

    assign out_free   = !out_v_reg || m_axis_tready;
    assign s2_produce = s2_keep || s2_fin_reg;
    assign s2_move    = s2_v_reg && (!s2_produce || out_free);
    assign s2_free    = !s2_v_reg || s2_move;
    assign s1_move    = s1_v_reg && s2_free;
    assign s1_free    = !s1_v_reg || s1_move;

    assign s_axis_tready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= done;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_move;
            end
            if (out_free)
            begin
                out_v_reg <= s2_move && s2_produce;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: anchor snapshot, threshold arrives from RAM
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] s1_box_reg [4];
    logic [SCORE_W-1:0]        s1_score_reg;
    logic [CLASS_W-1:0]        s1_class_reg;
    logic                      s1_fin_reg;
    logic                      s1_use_tbl_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free && done)
        begin
            s1_box_reg[0]  <= box_reg[0];
            s1_box_reg[1]  <= box_reg[1];
            s1_box_reg[2]  <= box_reg[2];
            s1_box_reg[3]  <= box_reg[3];
            s1_score_reg   <= best_score_next;
            s1_class_reg   <= best_class_next;
            s1_fin_reg     <= s_axis_tlast;
            s1_use_tbl_reg <= use_table;
        end
    end

    // clamp limits in 5 fraction bits
    logic [NET_W-1:0]   net_w_eff, net_h_eff;
    logic [COORD_W-1:0] wlim, hlim;

    assign net_w_eff = (net_width_reg  > MAX_NET) ? MAX_NET : net_width_reg;
    assign net_h_eff = (net_height_reg > MAX_NET) ? MAX_NET : net_height_reg;
    assign wlim      = {net_w_eff, 5'd0};
    assign hlim      = {net_h_eff, 5'd0};

    // corner = 2*center -/+ size, clamped to [0, lim]
    function automatic logic [COORD_W-1:0] clamp_corner(
        input logic signed [VALUE_W+1:0] v,
        input logic [COORD_W-1:0]        lim
    );
        logic [COORD_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({4'd0, lim}))
        begin
            r = lim;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    logic signed [VALUE_W+1:0] cx2, cy2, bw, bh;
    logic [SCORE_W-1:0]        s1_thr;
    logic                      s1_thr_ok;

    assign cx2 = (VALUE_W+2)'(s1_box_reg[0]) <<< 1;
    assign cy2 = (VALUE_W+2)'(s1_box_reg[1]) <<< 1;
    assign bw  = (VALUE_W+2)'(s1_box_reg[2]);
    assign bh  = (VALUE_W+2)'(s1_box_reg[3]);

    assign s1_thr    = s1_use_tbl_reg ? thr_rdata : DEFAULT_THRESHOLD;
    assign s1_thr_ok = (s1_score_reg >= s1_thr);

    // ------------------------------------------------------------------
    // Stage 2: clamped corners
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg;
    logic [SCORE_W-1:0] s2_score_reg;
    logic [CLASS_W-1:0] s2_class_reg;
    logic               s2_thr_ok_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_x1_reg     <= clamp_corner(cx2 - bw, wlim);
            s2_y1_reg     <= clamp_corner(cy2 - bh, hlim);
            s2_x2_reg     <= clamp_corner(cx2 + bw, wlim);
            s2_y2_reg     <= clamp_corner(cy2 + bh, hlim);
            s2_score_reg  <= s1_score_reg;
            s2_class_reg  <= s1_class_reg;
            s2_fin_reg    <= s1_fin_reg;
            s2_thr_ok_reg <= s1_thr_ok;
        end
    end

    // size check
    logic signed [COORD_W:0] s2_w, s2_h;

    assign s2_w    = $signed({1'b0, s2_x2_reg}) - $signed({1'b0, s2_x1_reg});
    assign s2_h    = $signed({1'b0, s2_y2_reg}) - $signed({1'b0, s2_y1_reg});
    assign s2_keep = s2_thr_ok_reg
                     && (s2_w >= (COORD_W+1)'(MIN_SIZE))
                     && (s2_h >= (COORD_W+1)'(MIN_SIZE));

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_det_reg;
    logic                 out_fin_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && s2_move && s2_produce)
        begin
            out_det_reg <= s2_keep;
            out_fin_reg <= s2_fin_reg;
            if (s2_keep)
            begin
                out_data_reg <= {1'b0,
                                 s2_h[COORD_W-1:0],
                                 s2_w[COORD_W-1:0],
                                 s2_y1_reg,
                                 s2_x1_reg,
                                 s2_score_reg,
                                 s2_class_reg};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_det_reg;
    assign m_axis_tlast  = out_fin_reg;

endmodule

@@ dv/detection_box_decoder_test.sv @@
// ----------------------------------------------------------------------------
// detection_box_decoder_test
// Self-checking testbench for the detection box decoder. Anchors and
// threshold writes go in on the input stream while an in-bench model of the
// argmax, threshold lookup and corner clamp predicts every box result. Named
// tests cover reset values, the table, score ties and saturation, box
// geometry, network size limits, class counts, and updates in mid anchor.
// They are followed by backpressure and randomized traffic under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module detection_box_decoder_test;

    import dbd_pkg::*;

    localparam int          MAX_CLS      = 128;
    localparam int          DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          HOLD_CYCLES  = 400;

    // One box result as seen on the output stream
    typedef struct {
        logic              detected;
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic              frame_end;
    } box_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index     = '0;
    logic [NET_W-1:0]     cfg_data      = '0;

    // Predicted decoder state and configuration
    int unsigned   cur_classes    = 80;
    int unsigned   cur_thresholds = 0;
    int unsigned   cur_net_w      = 640;
    int unsigned   cur_net_h      = 640;
    int unsigned   anchor_pos     = 0;
    int            box_val [4]    = '{0, 0, 0, 0};
    int unsigned   best_score     = 0;
    int unsigned   best_class     = 0;
    logic [15:0]   thr_table [TABLE_DEPTH];

    box_result_t   expected_boxes [$];
    box_result_t   got_box;
    box_result_t   want_box;

    int unsigned   src_idle_pct  = 0;
    int unsigned   sink_stall_pct = 0;
    bit            sink_hold     = 1'b0;
    int unsigned   items_sent    = 0;
    int unsigned   results_seen  = 0;
    int unsigned   errors        = 0;
    int unsigned   cycle_count   = 0;

    detection_box_decoder #(
        .MAX_CLASSES (MAX_CLS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned sat_score(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_net(int unsigned n);
        return (n > MAX_NET) ? MAX_NET : n;
    endfunction

    function automatic int unsigned eff_classes();
        if (cur_classes == 0)
            return 1;
        if (cur_classes > MAX_CLS)
            return MAX_CLS;
        return cur_classes;
    endfunction

    // Advance the decoder by one accepted request; queue a box if one comes
    function automatic void decode_value(mode_t mode, logic [VALUE_W-1:0] raw,
                                         logic [TABLE_AW-1:0] index, logic fin);
        int          v;
        int unsigned thr;
        int          wlim;
        int          hlim;
        int          x1;
        int          y1;
        int          x2;
        int          y2;
        bit          keep;
        box_result_t r;

        v = $signed(raw);
        if (mode == MODE_TABLE)
        begin
            thr_table[index] = 16'(sat_score(v));
            return;
        end
        if (anchor_pos < 4)
        begin
            box_val[anchor_pos] = v;
            anchor_pos++;
            return;
        end
        // running argmax, ties stay with the lower class
        if (anchor_pos == 4 || sat_score(v) > best_score)
        begin
            best_score = sat_score(v);
            best_class = (anchor_pos - 4) & 32'h7F;
        end
        if (anchor_pos < 3 + eff_classes())
        begin
            anchor_pos++;
            return;
        end
        anchor_pos = 0;

        thr = DEFAULT_THRESHOLD;
        if (best_class < cur_thresholds)
            thr = 32'(thr_table[best_class]);
        keep = (best_score >= thr);
        wlim = eff_net(cur_net_w) * 32;
        hlim = eff_net(cur_net_h) * 32;
        x1 = clamp_coord(2 * box_val[0] - box_val[2], wlim);
        y1 = clamp_coord(2 * box_val[1] - box_val[3], hlim);
        x2 = clamp_coord(2 * box_val[0] + box_val[2], wlim);
        y2 = clamp_coord(2 * box_val[1] + box_val[3], hlim);
        if (x2 - x1 < MIN_SIZE || y2 - y1 < MIN_SIZE)
            keep = 1'b0;
        if (!keep && !fin)
            return;

        r = '{default: '0};
        if (keep)
        begin
            r.detected = 1'b1;
            r.class_id = CLASS_W'(best_class);
            r.score    = SCORE_W'(best_score);
            r.left     = COORD_W'(x1);
            r.top      = COORD_W'(y1);
            r.width    = COORD_W'(x2 - x1);
            r.height   = COORD_W'(y2 - y1);
        end
        r.frame_end = fin;
        expected_boxes.insert(expected_boxes.size(), r);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        errors++;
        if (errors <= 100)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got, want, results_seen);
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare every accepted result with the oldest predicted box
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got_box.detected  = m_axis_tuser;
            got_box.class_id  = m_axis_tdata[6:0];
            got_box.score     = m_axis_tdata[22:7];
            got_box.left      = m_axis_tdata[40:23];
            got_box.top       = m_axis_tdata[58:41];
            got_box.width     = m_axis_tdata[76:59];
            got_box.height    = m_axis_tdata[94:77];
            got_box.frame_end = m_axis_tlast;
            if (expected_boxes.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata[63:0], 0);
            else
            begin
                want_box = expected_boxes.pop_front();
                check_field("detected",  got_box.detected,  want_box.detected);
                check_field("class_id",  got_box.class_id,  want_box.class_id);
                check_field("score",     got_box.score,     want_box.score);
                check_field("left",      got_box.left,      want_box.left);
                check_field("top",       got_box.top,       want_box.top);
                check_field("width",     got_box.width,     want_box.width);
                check_field("height",    got_box.height,    want_box.height);
                check_field("frame_end", got_box.frame_end, want_box.frame_end);
                check_field("tdata pad", m_axis_tdata[95],  0);
            end
        end
    end

    // Output side: random stall, or a long hold-off during the pressure test
    always @(negedge clk)
    begin
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One input request; returns at the accepting edge with tvalid still high
    task automatic send_item(mode_t mode, int value, int unsigned index, bit fin);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= fin;
        s_axis_tdata  <= {5'b0, index[6:0], value[19:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_value(mode, value[19:0], index[6:0], fin);
        items_sent++;
    endtask

    task automatic send_score(int value, bit fin);
        send_item(MODE_ANCHOR, value, $urandom_range(127), fin);
    endtask

    task automatic send_box(int cx, int cy, int bw, int bh, bit fin);
        send_score(cx, fin);
        send_score(cy, fin);
        send_score(bw, fin);
        send_score(bh, fin);
    endtask

    // Stop the input and wait until all predicted boxes are out
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t index, int unsigned data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data[12:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_NUM_CLASSES:    cur_classes    = data & 32'hFF;
            CFG_NUM_THRESHOLDS: cur_thresholds = data & 32'hFF;
            CFG_NET_WIDTH:      cur_net_w      = data & 32'h1FFF;
            CFG_NET_HEIGHT:     cur_net_h      = data & 32'h1FFF;
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int unsigned classes, int unsigned thresholds,
                              int unsigned net_w, int unsigned net_h);
        wait_drained();
        write_reg(CFG_NUM_CLASSES, classes);
        write_reg(CFG_NUM_THRESHOLDS, thresholds);
        write_reg(CFG_NET_WIDTH, net_w);
        write_reg(CFG_NET_HEIGHT, net_h);
    endtask

    // One well-formed anchor with random content, plus occasional noise
    task automatic send_random_anchor();
        int unsigned classes;
        int unsigned k;
        int unsigned sel;
        int          lim_w;
        int          lim_h;
        int          cx;
        int          cy;
        int          bw;
        int          bh;
        int          s;
        int          prev;
        bit          fin;

        classes = eff_classes();
        fin     = ($urandom_range(3) == 0);
        lim_w   = (eff_net(cur_net_w) == 0) ? 16 : eff_net(cur_net_w) * 16;
        lim_h   = (eff_net(cur_net_h) == 0) ? 16 : eff_net(cur_net_h) * 16;
        if ($urandom_range(9) == 0)
        begin
            cx = $urandom;
            cy = $urandom;
            bw = $urandom;
            bh = $urandom;
        end
        else
        begin
            cx = int'($urandom_range(lim_w + lim_w / 4)) - lim_w / 8;
            cy = int'($urandom_range(lim_h + lim_h / 4)) - lim_h / 8;
            bw = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(lim_w / 2);
            bh = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(lim_h / 2);
            if ($urandom_range(15) == 0)
                bw = -bw;
            if ($urandom_range(15) == 0)
                bh = -bh;
        end
        send_box(cx, cy, bw, bh, bit'($urandom_range(1)));

        prev = 0;
        for (k = 0; k < classes; k++)
        begin
            sel = $urandom_range(19);
            if (sel == 0)
                s = -int'($urandom_range(1, 524288));
            else if (sel == 1)
                s = $urandom_range(65536, 524287);
            else if (sel <= 4 && k > 0)
                s = prev;
            else
                s = $urandom_range(65535);
            // threshold write slipped into the anchor
            if ($urandom_range(24) == 0)
                send_item(MODE_TABLE,
                          ($urandom_range(9) == 0) ? int'($urandom) : $urandom_range(16'h6000),
                          $urandom_range(127), bit'($urandom_range(1)));
            send_score(s, (k == classes - 1) ? fin : bit'($urandom_range(1)));
            prev = s;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset configuration: 80 classes, default threshold, 640 x 640
    task automatic test_reset_defaults();
        int unsigned k;

        send_box(320 * 16, 240 * 16, 50 * 16, 40 * 16, 1'b0);
        for (k = 0; k < 80; k++)
            send_score($urandom_range(65535), k == 79);
    endtask

    // Fill every table entry so no lookup ever hits an unwritten one
    task automatic test_threshold_table();
        int unsigned k;
        int          v;

        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            case (k)
                0:       v = -1;
                1:       v = -524288;
                2:       v = 524287;
                3:       v = 65536;
                127:     v = 16'h1000;
                default: v = $urandom_range(16'h6000);
            endcase
            send_item(MODE_TABLE, v, k, bit'($urandom_range(1)));
        end
    endtask

    // Argmax ties, score saturation and the default threshold edge
    task automatic test_score_selection();
        set_config(3, 0, 640, 640);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(16'h8000, 1'b0);
        send_score(16'h8000, 1'b0);
        send_score(16'h7000, 1'b0);
        send_box(5120, 4000, 800, 1200, 1'b0);
        send_score(-5, 1'b0);
        send_score(70000, 1'b0);
        send_score(65535, 1'b0);
        // below 0.25: silent without the frame marker, empty result with it
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(16'h3FFF, 1'b0);
        send_score(0, 1'b0);
        send_score(0, 1'b0);
        send_box(5120, 5120, 1600, 1600, 1'b1);
        send_score(16'h3FFF, 1'b1);
        send_score(0, 1'b1);
        send_score(0, 1'b1);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(0, 1'b0);
        send_score(16'h4000, 1'b0);
        send_score(16'h4000, 1'b1);
    endtask

    // Clamping at both edges, the one-pixel limit and value extremes
    task automatic test_box_geometry();
        set_config(1, 0, 640, 640);
        send_box(-1000, 5120, 524287, 1600, 1'b0);
        send_score(16'hFFFF, 1'b0);
        send_box(-524288, 524287, 100, -524288, 1'b1);
        send_score(16'hFFFF, 1'b1);
        send_box(5120, 5120, 16, 16, 1'b0);
        send_score(16'h9000, 1'b0);
        send_box(5120, 5120, 15, 16, 1'b1);
        send_score(16'h9000, 1'b1);
        send_box(700 * 16, 5120, 100, 100, 1'b0);
        send_score(16'h9000, 1'b0);
    endtask

    // Zero size drops all, oversize acts as 4096, a one-pixel network
    task automatic test_net_limits();
        set_config(1, 0, 0, 640);
        send_box(5120, 5120, 1600, 1600, 1'b1);
        send_score(16'hFFFF, 1'b1);
        set_config(1, 0, 8191, 4096);
        send_box(0, 0, 524287, 524287, 1'b0);
        send_score(16'hC000, 1'b0);
        set_config(1, 0, 1, 1);
        send_box(8, 8, 16, 16, 1'b1);
        send_score(16'h8000, 1'b1);
    endtask

    // Class count of 0 and above the maximum; threshold count past the table
    task automatic test_class_counts();
        int unsigned k;

        set_config(0, 255, 640, 640);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(16'hFFFF, 1'b0);
        set_config(255, 128, 640, 640);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        for (k = 0; k < MAX_CLS; k++)
            send_score((k == MAX_CLS - 1) ? 16'hFFFF : 16'h0100, k == MAX_CLS - 1);
    endtask

    // Class count shrunk and a threshold rewritten while an anchor is open
    task automatic test_mid_anchor_updates();
        set_config(6, 0, 640, 640);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(16'h9000, 1'b0);
        send_score(16'h1000, 1'b0);
        wait_drained();
        write_reg(CFG_NUM_CLASSES, 2);
        send_score(16'h9500, 1'b1);

        set_config(2, 128, 640, 640);
        send_box(5120, 5120, 1600, 1600, 1'b0);
        send_score(16'h7000, 1'b0);
        send_item(MODE_TABLE, 16'hFFFF, 0, 1'b0);
        send_score(16'h0100, 1'b1);
    endtask

    // Output held off for a long stretch while anchors keep coming
    task automatic test_backpressure();
        int unsigned k;

        set_config(1, 0, 640, 640);
        sink_hold = 1'b1;
        fork
            begin : hold_off
                int unsigned n;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                sink_hold = 1'b0;
            end
            begin
                for (k = 0; k < 40; k++)
                begin
                    send_box(4000 + k * 16, 3000, 800, 600, 1'b0);
                    send_score(16'h8000 + k, k == 39);
                end
            end
        join
    endtask

    task automatic pick_random_config();
        int unsigned sel;
        int unsigned classes;
        int unsigned thresholds;
        int unsigned net_w;
        int unsigned net_h;

        sel = $urandom_range(19);
        if (sel == 0)
            classes = 0;
        else if (sel == 1)
            classes = 128;
        else if (sel == 2)
            classes = 255;
        else
            classes = $urandom_range(1, 6);
        sel = $urandom_range(5);
        thresholds = (sel == 0) ? 0 : (sel == 1) ? 128 : (sel == 2) ? 255 :
                     $urandom_range(8);
        sel = $urandom_range(9);
        net_w = (sel == 0) ? 1 : (sel == 1) ? 4096 : (sel == 2) ? 8191 :
                (sel == 3) ? 0 : $urandom_range(16, 1024);
        sel = $urandom_range(9);
        net_h = (sel == 0) ? 1 : (sel == 1) ? 4096 : (sel == 2) ? 8191 :
                (sel == 3) ? 0 : $urandom_range(16, 1024);
        set_config(classes, thresholds, net_w, net_h);
    endtask

    // Random anchors under each idle mix, two settings per mix
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned round;
        int unsigned start;
        int unsigned first_result;

        first_result = results_seen;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            for (round = 0; round < 2; round++)
            begin
                pick_random_config();
                start = items_sent;
                while (items_sent - start < 40)
                    send_random_anchor();
            end
        end
        while (results_seen + expected_boxes.size() - first_result < 48)
            send_random_anchor();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_threshold_table();
        test_score_selection();
        test_box_geometry();
        test_net_limits();
        test_class_counts();
        test_mid_anchor_updates();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ detection_box_decoder.f @@
rtl/core/dbd_pkg.sv
rtl/core/dbd_ram.sv
rtl/core/detection_box_decoder.sv
dv/detection_box_decoder_test.sv
